### hw/rtl/sbi_pkg.sv
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared constants for the segment/box slab test pipeline.
// ----------------------------------------------------------------------------
package sbi_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int T_W             = 32;   // Q16.16 slab parameter
  localparam int Q_W             = 31;   // unsigned quotient bits below saturation
  localparam int FRAC_W          = 16;
  localparam int AXES            = 3;
  localparam int CFG_IDX_W       = 3;
  localparam logic signed [T_W-1:0] T_ONE  = 32'sd65536;
  localparam logic signed [T_W-1:0] T_ZERO = 32'sd0;
  localparam logic signed [T_W-1:0] T_POS_SAT = 32'sh7FFF_FFFF;
  localparam logic signed [T_W-1:0] T_NEG_SAT = 32'sh8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;
endpackage

### hw/rtl/sbi_qdiv.sv
// ----------------------------------------------------------------------------
// sbi_qdiv
// Pipelined restoring divider: floor(nm * 2^16 / dm), one bit per stage,
// with a saturation flag when the quotient would reach 2^31.
// ----------------------------------------------------------------------------
module sbi_qdiv
  import sbi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [COORD_WIDTH:0] nm_i,
  input  logic [COORD_WIDTH:0] dm_i,
  output logic                 sat_o,
  output logic [Q_W-1:0]       q_o
);
  localparam int MW = COORD_WIDTH + 1;
  localparam int SH = Q_W - FRAC_W;   // 15

  logic [MW-1:0]  r_r   [0:Q_W];
  logic [MW-1:0]  dm_r  [0:Q_W];
  logic [Q_W-1:0] w_r   [0:Q_W];
  logic           sat_r [0:Q_W];

  // initial partial remainder: nm >> 15; low numerator bits queue in w
  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= ({{SH{1'b0}}, nm_i} >= {dm_i, {SH{1'b0}}});
      r_r[0]   <= nm_i >> SH;
      w_r[0]   <= {nm_i[SH-1:0], {FRAC_W{1'b0}}};
      dm_r[0]  <= dm_i;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [MW:0]   tr;
    logic [MW:0]   dif;
    logic          ge;
    logic [MW-1:0] r_nxt;
    assign tr    = {r_r[k-1], w_r[k-1][Q_W-1]};
    assign ge    = (tr >= {1'b0, dm_r[k-1]});
    assign dif   = tr - {1'b0, dm_r[k-1]};
    assign r_nxt = ge ? dif[MW-1:0] : tr[MW-1:0];
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= r_nxt;
        w_r[k]   <= {w_r[k-1][Q_W-2:0], ge};
        dm_r[k]  <= dm_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign sat_o = sat_r[Q_W];
  assign q_o   = w_r[Q_W];
endmodule

### hw/rtl/segment_box_intersect.sv
// ----------------------------------------------------------------------------
// segment_box_intersect
// Slab test of a line segment against a configured axis-aligned box.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata: begin x,y,z, end x,y,z
//  out_    | out | out_tvalid/out_tready | out_tdata[0]: hit
//  cfg_    | in  | cfg_we                | cfg_addr register index, cfg_wdata
//
//  One transaction enters per cycle while out_ is not stalled. The pipe holds
//  the difference stage, the pipelined divider, the sign-and-saturate stage,
//  the ordering stage and two intersection stages.
//  Reset (rst_n low, synchronous) empties the pipe and loads the unit box.
//  A stall on out_ freezes the whole pipe; in_tready follows it.
// ----------------------------------------------------------------------------
module segment_box_intersect
  import sbi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // begin_x, begin_y, begin_z, end_x, end_y, end_z from the lowest bit up
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // hit in bit 0, rest zero
  output logic [7:0]             out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [COORD_WIDTH-1:0] cfg_wdata
);
  localparam int CW  = COORD_WIDTH;
  localparam int MW  = CW + 1;
  localparam int DLY = Q_W + 1;          // divider latency
  localparam int NST = 1 + DLY + 4;      // total pipe stages

  typedef struct packed {
    logic neg0;
    logic neg1;
    logic stat;    // axis does not move
    logic pmiss;   // stationary begin outside slab
  } side_t;

  logic en;
  logic [NST-1:0] v_r;

  logic signed [CW-1:0] box_lo_r [AXES];
  logic signed [CW-1:0] box_hi_r [AXES];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        box_lo_r[a] <= '0;
        box_hi_r[a] <= CW'(64'sd65536);
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_X: box_lo_r[0] <= cfg_wdata;
        REG_MIN_Y: box_lo_r[1] <= cfg_wdata;
        REG_MIN_Z: box_lo_r[2] <= cfg_wdata;
        REG_MAX_X: box_hi_r[0] <= cfg_wdata;
        REG_MAX_Y: box_hi_r[1] <= cfg_wdata;
        REG_MAX_Z: box_hi_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipe advances together; output register frees the front
  assign en        = !v_r[NST-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_tvalid};
    end
  end

  // stage 0: differences as sign and magnitude
  logic [MW-1:0] dm_nxt [AXES], nm0_nxt [AXES], nm1_nxt [AXES];
  side_t         sd_nxt [AXES];
  logic [MW-1:0] dm_r   [AXES], nm0_r   [AXES], nm1_r   [AXES];
  side_t         sd_r   [DLY+1][AXES];

  always_comb begin
    logic signed [CW-1:0] b, e;
    logic signed [CW:0]   d, n0, n1;
    for (int a = 0; a < AXES; a++) begin
      b  = in_tdata[a*CW +: CW];
      e  = in_tdata[(a+3)*CW +: CW];
      d  = {e[CW-1], e} - {b[CW-1], b};
      n0 = {box_lo_r[a][CW-1], box_lo_r[a]} - {b[CW-1], b};
      n1 = {box_hi_r[a][CW-1], box_hi_r[a]} - {b[CW-1], b};
      dm_nxt[a]        = d[CW] ? MW'(-d) : MW'(d);
      nm0_nxt[a]       = n0[CW] ? MW'(-n0) : MW'(n0);
      nm1_nxt[a]       = n1[CW] ? MW'(-n1) : MW'(n1);
      sd_nxt[a].neg0   = n0[CW] ^ d[CW];
      sd_nxt[a].neg1   = n1[CW] ^ d[CW];
      sd_nxt[a].stat   = (d == '0);
      sd_nxt[a].pmiss  = (b < box_lo_r[a]) || (box_hi_r[a] < b);
      // keep the divider away from a zero divisor; result unused then
      if (d == '0) dm_nxt[a] = MW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        dm_r[a]     <= dm_nxt[a];
        nm0_r[a]    <= nm0_nxt[a];
        nm1_r[a]    <= nm1_nxt[a];
        sd_r[0][a]  <= sd_nxt[a];
        for (int k = 1; k <= DLY; k++) sd_r[k][a] <= sd_r[k-1][a];
      end
    end
  end

  // two dividers per axis, one for each bound
  logic           sat0 [AXES], sat1 [AXES];
  logic [Q_W-1:0] q0   [AXES], q1   [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    sbi_qdiv #(.COORD_WIDTH(CW)) u_div0 (
      .clk(clk), .en(en), .nm_i(nm0_r[a]), .dm_i(dm_r[a]),
      .sat_o(sat0[a]), .q_o(q0[a])
    );
    sbi_qdiv #(.COORD_WIDTH(CW)) u_div1 (
      .clk(clk), .en(en), .nm_i(nm1_r[a]), .dm_i(dm_r[a]),
      .sat_o(sat1[a]), .q_o(q1[a])
    );
  end

  // sign and saturate
  logic signed [T_W-1:0] t0_r [AXES], t1_r [AXES];
  side_t                 sa_r [AXES];

  function automatic logic signed [T_W-1:0] signed_t(logic sat, logic neg,
                                                     logic [Q_W-1:0] q);
    logic signed [T_W-1:0] m;
    m = {1'b0, q};
    if (sat) return neg ? T_NEG_SAT : T_POS_SAT;
    return neg ? -m : m;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        t0_r[a] <= signed_t(sat0[a], sd_r[DLY][a].neg0, q0[a]);
        t1_r[a] <= signed_t(sat1[a], sd_r[DLY][a].neg1, q1[a]);
        sa_r[a] <= sd_r[DLY][a];
      end
    end
  end

  // order per axis and axis miss
  logic signed [T_W-1:0] lo_r [AXES], hi_r [AXES];
  logic                  mis_r [AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        if (sa_r[a].stat) begin
          lo_r[a]  <= T_ZERO;
          hi_r[a]  <= T_ONE;
          mis_r[a] <= sa_r[a].pmiss;
        end else if (t0_r[a] < t1_r[a]) begin
          lo_r[a]  <= t0_r[a];
          hi_r[a]  <= t1_r[a];
          mis_r[a] <= (t1_r[a] < T_ZERO) || (t0_r[a] > T_ONE);
        end else begin
          lo_r[a]  <= t1_r[a];
          hi_r[a]  <= t0_r[a];
          mis_r[a] <= (t0_r[a] < T_ZERO) || (t1_r[a] > T_ONE);
        end
      end
    end
  end

  // intersect x with y
  logic signed [T_W-1:0] xy_lo_r, xy_hi_r, z_lo_r, z_hi_r;
  logic                  xy_mis_r, z_mis_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xy_mis_r <= mis_r[0] || mis_r[1] ||
                  (hi_r[0] < lo_r[1]) || (lo_r[0] > hi_r[1]);
      xy_lo_r  <= (lo_r[0] < lo_r[1]) ? lo_r[1] : lo_r[0];
      xy_hi_r  <= (hi_r[0] > hi_r[1]) ? hi_r[1] : hi_r[0];
      z_lo_r   <= lo_r[2];
      z_hi_r   <= hi_r[2];
      z_mis_r  <= mis_r[2];
    end
  end

  // intersect with z and final range check into the output register
  logic signed [T_W-1:0] f_lo, f_hi;
  logic                  hit_nxt, hit_r;

  always_comb begin
    f_lo    = (xy_lo_r < z_lo_r) ? z_lo_r : xy_lo_r;
    f_hi    = (xy_hi_r > z_hi_r) ? z_hi_r : xy_hi_r;
    hit_nxt = !(xy_mis_r || z_mis_r || (xy_hi_r < z_lo_r) || (xy_lo_r > z_hi_r) ||
                (f_lo > T_ONE) || (f_hi < T_ZERO));
  end

  always_ff @(posedge clk) begin
    if (en) hit_r <= hit_nxt;
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = {7'b0, hit_r};
endmodule
